FILE: design/bsrm_pkg.sv
// ----------------------------------------------------------------------------
// bsrm_pkg
// Shared types and constants of the byte stream register machine: opcodes,
// status codes, decoded instruction and result records, queue sizing.
// ----------------------------------------------------------------------------
package bsrm_pkg;

   localparam int PROGRAM_BYTES = 1024;
   localparam int NUM_REGS      = 6;

   localparam int POS_W     = $clog2(PROGRAM_BYTES + 1);
   localparam int POS_OUT_W = 11;
   localparam int POSX_W    = (POS_W > POS_OUT_W) ? POS_W : POS_OUT_W;
   localparam int RF_AW     = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

   localparam int QUEUE_DEPTH = 2;
   localparam int Q_PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] OP_LDI  = 8'hB8;
   localparam logic [7:0] OP_ADDI = 8'h83;
   localparam logic [7:0] OP_SUBI = 8'h84;
   localparam logic [7:0] OP_MOVR = 8'h89;
   localparam logic [7:0] OP_CMP  = 8'h85;
   localparam logic [7:0] OP_RET  = 8'hC3;

   localparam logic [1:0] FLAG_EQ = 2'h1;
   localparam logic [1:0] FLAG_NE = 2'h2;

   typedef enum logic [2:0] {
      ST_PEND   = 3'd0,
      ST_DONE   = 3'd1,
      ST_RET    = 3'd2,
      ST_BADOP  = 3'd3,
      ST_BADREG = 3'd4,
      ST_SPACE  = 3'd5,
      ST_HALT   = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      OPK_LDI  = 3'd0,
      OPK_ADDI = 3'd1,
      OPK_SUBI = 3'd2,
      OPK_MOVR = 3'd3,
      OPK_CMP  = 3'd4,
      OPK_NONE = 3'd5
   } opk_type;

   typedef enum logic [1:0] {
      PH_OPCODE = 2'd0,
      PH_DEST   = 2'd1,
      PH_OPND   = 2'd2,
      PH_HIGH   = 2'd3
   } phase_type;

   typedef struct packed {
      opk_type              kind;
      status_type           status;
      logic [2:0]           dest;
      logic [2:0]           src;
      logic [15:0]          imm;
      logic [POS_OUT_W-1:0] position;
   } dec_op_type;

   typedef struct packed {
      status_type           status;
      logic                 wrote_reg;
      logic [2:0]           reg_index;
      logic [15:0]          reg_value;
      logic [1:0]           flags;
      logic [POS_OUT_W-1:0] position;
   } rsp_type;

endpackage

FILE: design/bsrm_front.sv
// ----------------------------------------------------------------------------
// bsrm_front
// Decoder: takes program bytes, tracks decode phase, byte position and halt,
// and emits one decoded record per byte with its status already settled.
// ----------------------------------------------------------------------------
module bsrm_front
   import bsrm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  logic [7:0] req_code_byte,
   input  logic       q_full,
   output logic       q_push,
   output dec_op_type q_op
);

   localparam logic [POS_W-1:0] PROG_LIMIT = POS_W'(PROGRAM_BYTES);

   phase_type         phase_ff, phase_in;
   logic              halted_ff, halted_in;
   opk_type           kind_ff, kind_in;
   logic [2:0]        dest_ff, dest_in;
   logic [7:0]        low_ff, low_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [POSX_W-1:0] pos_wide;
   logic              accept;
   logic              byte_is_reg;

   assign accept      = req_push && !q_full;
   assign q_push      = accept;
   assign pos_wide    = POSX_W'(pos_ff);
   assign byte_is_reg = req_code_byte < 8'(NUM_REGS);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_OPCODE;
         halted_ff <= 1'b0;
         kind_ff   <= OPK_LDI;
         dest_ff   <= '0;
         low_ff    <= '0;
         pos_ff    <= '0;
      end else begin
         phase_ff  <= phase_in;
         halted_ff <= halted_in;
         kind_ff   <= kind_in;
         dest_ff   <= dest_in;
         low_ff    <= low_in;
         pos_ff    <= pos_in;
      end
   end

   always_comb begin
      phase_in    = phase_ff;
      halted_in   = halted_ff;
      kind_in     = kind_ff;
      dest_in     = dest_ff;
      low_in      = low_ff;
      pos_in      = pos_ff;
      q_op.kind     = OPK_NONE;
      q_op.status   = ST_PEND;
      q_op.dest     = dest_ff;
      q_op.src      = req_code_byte[2:0];
      q_op.imm      = {req_code_byte, low_ff};
      q_op.position = pos_wide[POS_OUT_W-1:0];
      if (accept) begin
         if (halted_ff) begin
            q_op.status   = ST_HALT;
            q_op.position = '0;
         end else begin
            if (pos_ff < PROG_LIMIT) begin
               pos_in = pos_ff + 1'b1;
            end
            if (pos_ff >= PROG_LIMIT) begin
               q_op.status = ST_SPACE;
               halted_in   = 1'b1;
            end else begin
               case (phase_ff)
                  PH_OPCODE: begin
                     phase_in = PH_DEST;
                     case (req_code_byte)
                        OP_LDI:  kind_in = OPK_LDI;
                        OP_ADDI: kind_in = OPK_ADDI;
                        OP_SUBI: kind_in = OPK_SUBI;
                        OP_MOVR: kind_in = OPK_MOVR;
                        OP_CMP:  kind_in = OPK_CMP;
                        OP_RET: begin
                           q_op.status = ST_RET;
                           halted_in   = 1'b1;
                           phase_in    = PH_OPCODE;
                        end
                        default: begin
                           q_op.status = ST_BADOP;
                           halted_in   = 1'b1;
                           phase_in    = PH_OPCODE;
                        end
                     endcase
                  end
                  PH_DEST: begin
                     if (!byte_is_reg) begin
                        q_op.status = ST_BADREG;
                        halted_in   = 1'b1;
                        phase_in    = PH_OPCODE;
                     end else begin
                        dest_in  = req_code_byte[2:0];
                        phase_in = PH_OPND;
                     end
                  end
                  PH_OPND: begin
                     if (kind_ff inside {OPK_MOVR, OPK_CMP}) begin
                        phase_in = PH_OPCODE;
                        if (!byte_is_reg) begin
                           q_op.status = ST_BADREG;
                           halted_in   = 1'b1;
                        end else begin
                           q_op.kind   = kind_ff;
                           q_op.status = ST_DONE;
                        end
                     end else begin
                        low_in   = req_code_byte;
                        phase_in = PH_HIGH;
                     end
                  end
                  PH_HIGH: begin
                     phase_in    = PH_OPCODE;
                     q_op.kind   = kind_ff;
                     q_op.status = ST_DONE;
                  end
                  default: begin
                     phase_in = PH_OPCODE;
                  end
               endcase
            end
         end
      end
   end

endmodule

FILE: design/bsrm_queue.sv
// ----------------------------------------------------------------------------
// bsrm_queue
// Short first-in first-out queue of decoded records between the decoder and
// the execution stage.
// ----------------------------------------------------------------------------
module bsrm_queue
   import bsrm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  dec_op_type push_op,
   output logic       full,
   input  logic       pop,
   output logic       empty,
   output dec_op_type head_op
);

   dec_op_type         mem_ff [QUEUE_DEPTH];
   logic [Q_PTR_W-1:0] wptr_ff, wptr_in;
   logic [Q_PTR_W-1:0] rptr_ff, rptr_in;
   logic [Q_CNT_W-1:0] count_ff, count_in;
   logic               push_ok;
   logic               pop_ok;

   assign full    = count_ff == Q_CNT_W'(QUEUE_DEPTH);
   assign empty   = count_ff == '0;
   assign push_ok = push && !full;
   assign pop_ok  = pop && !empty;
   assign head_op = mem_ff[rptr_ff];

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (push_ok) begin
         wptr_in = (wptr_ff == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rptr_in = (rptr_ff == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem_ff[wptr_ff] <= push_op;
      end
   end

endmodule

FILE: design/bsrm_back.sv
// ----------------------------------------------------------------------------
// bsrm_back
// Execution stage: reads operands from the register file, performs the load,
// add, subtract, move or compare, keeps the sticky flags and queues results.
// ----------------------------------------------------------------------------
module bsrm_back
   import bsrm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       q_empty,
   input  dec_op_type q_op,
   output logic       q_pop,
   input  logic       rsp_pop,
   output logic       rsp_empty,
   output rsp_type    rsp_head
);

   logic [15:0]        rf_mem [NUM_REGS];
   logic [NUM_REGS-1:0] rf_valid_ff;

   logic               b_valid_ff, b_valid_in;
   dec_op_type         b_op_ff;
   logic [15:0]        b_dval_ff;
   logic [15:0]        b_sval_ff;
   logic               b_fire;
   logic               b_load;

   logic [1:0]         flags_ff, flags_in;
   logic               wr_en;
   logic [RF_AW-1:0]   wr_idx;
   logic [15:0]        wr_val;
   logic [RF_AW-1:0]   rd_didx;
   logic [RF_AW-1:0]   rd_sidx;
   rsp_type            res;

   rsp_type            out_mem_ff [QUEUE_DEPTH];
   logic [Q_PTR_W-1:0] owptr_ff, owptr_in;
   logic [Q_PTR_W-1:0] orptr_ff, orptr_in;
   logic [Q_CNT_W-1:0] ocount_ff, ocount_in;
   logic               out_full;
   logic               out_pop;

   assign out_full  = ocount_ff == Q_CNT_W'(QUEUE_DEPTH);
   assign rsp_empty = ocount_ff == '0;
   assign out_pop   = rsp_pop && !rsp_empty;
   assign rsp_head  = out_mem_ff[orptr_ff];

   assign b_fire     = b_valid_ff && !out_full;
   assign b_load     = !q_empty && (!b_valid_ff || b_fire);
   assign q_pop      = b_load;
   assign b_valid_in = b_load ? 1'b1 : (b_fire ? 1'b0 : b_valid_ff);
   assign rd_didx    = q_op.dest[RF_AW-1:0];
   assign rd_sidx    = q_op.src[RF_AW-1:0];
   assign wr_idx     = b_op_ff.dest[RF_AW-1:0];

   always_comb begin
      wr_en    = 1'b0;
      wr_val   = '0;
      flags_in = flags_ff;
      case (b_op_ff.kind)
         OPK_LDI: begin
            wr_en  = 1'b1;
            wr_val = b_op_ff.imm;
         end
         OPK_ADDI: begin
            wr_en  = 1'b1;
            wr_val = b_dval_ff + b_op_ff.imm;
         end
         OPK_SUBI: begin
            wr_en  = 1'b1;
            wr_val = b_dval_ff - b_op_ff.imm;
         end
         OPK_MOVR: begin
            wr_en  = 1'b1;
            wr_val = b_sval_ff;
         end
         OPK_CMP: begin
            flags_in = flags_ff | ((b_dval_ff == b_sval_ff) ? FLAG_EQ : FLAG_NE);
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
      wr_en = wr_en && b_fire;
      res.status    = b_op_ff.status;
      res.wrote_reg = wr_en;
      res.reg_index = wr_en ? b_op_ff.dest : 3'd0;
      res.reg_value = wr_en ? wr_val : 16'd0;
      res.flags     = flags_in;
      res.position  = b_op_ff.position;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff  <= 1'b0;
         flags_ff    <= '0;
         rf_valid_ff <= '0;
      end else begin
         b_valid_ff <= b_valid_in;
         if (b_fire) begin
            flags_ff <= flags_in;
         end
         if (wr_en) begin
            rf_valid_ff[wr_idx] <= 1'b1;
         end
      end
   end

   // An operand read in the same cycle as a write to that register takes
   // the value being written.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         rf_mem[wr_idx] <= wr_val;
      end
      if (b_load) begin
         b_op_ff <= q_op;
         if (wr_en && wr_idx == rd_didx) begin
            b_dval_ff <= wr_val;
         end else if (rf_valid_ff[rd_didx]) begin
            b_dval_ff <= rf_mem[rd_didx];
         end else begin
            b_dval_ff <= '0;
         end
         if (wr_en && wr_idx == rd_sidx) begin
            b_sval_ff <= wr_val;
         end else if (rf_valid_ff[rd_sidx]) begin
            b_sval_ff <= rf_mem[rd_sidx];
         end else begin
            b_sval_ff <= '0;
         end
      end
   end

   always_comb begin
      owptr_in  = owptr_ff;
      orptr_in  = orptr_ff;
      ocount_in = ocount_ff;
      if (b_fire) begin
         owptr_in = (owptr_ff == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : owptr_ff + 1'b1;
      end
      if (out_pop) begin
         orptr_in = (orptr_ff == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : orptr_ff + 1'b1;
      end
      if (b_fire && !out_pop) begin
         ocount_in = ocount_ff + 1'b1;
      end else if (out_pop && !b_fire) begin
         ocount_in = ocount_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         owptr_ff  <= '0;
         orptr_ff  <= '0;
         ocount_ff <= '0;
      end else begin
         owptr_ff  <= owptr_in;
         orptr_ff  <= orptr_in;
         ocount_ff <= ocount_in;
      end
   end

   always_ff @(posedge clock) begin
      if (b_fire) begin
         out_mem_ff[owptr_ff] <= res;
      end
   end

endmodule

FILE: design/byte_stream_register_machine_top.sv
// ----------------------------------------------------------------------------
// byte_stream_register_machine_top
// Decodes and executes a small register instruction set from a byte stream.
//
// The program enters one byte per transaction on the req_ queue port: a byte
// is taken on a rising edge with req_push high and req_full low. Every byte
// produces exactly one result on the rsp_ queue port, shown while rsp_empty
// is low and taken on an edge with rsp_pop high.
// The decoder settles decode phase, position and halt status in the cycle a
// byte is taken; a two-entry queue carries the decoded record to the
// execution stage, which reads the register file and does the 16-bit load,
// add, subtract, move or compare. A result passes through the input queue,
// the execution stage register and the output queue before it is shown, and
// one byte per cycle is sustained when the receiver pops every cycle.
// When the receiver stalls, results collect in a two-entry output queue,
// then the execution stage and the input queue fill, and req_full rises.
// Synchronous reset empties all queues, clears the registers, the flags and
// the decoder, and leaves the block ready for a new program.
// ----------------------------------------------------------------------------
module byte_stream_register_machine_top
   import bsrm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_code_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [2:0]  rsp_status,
   output logic        rsp_wrote_reg,
   output logic [2:0]  rsp_reg_index,
   output logic [15:0] rsp_reg_value,
   output logic [1:0]  rsp_flags,
   output logic [10:0] rsp_position
);

   logic       q_full;
   logic       q_push;
   logic       q_pop;
   logic       q_empty;
   dec_op_type front_op;
   dec_op_type head_op;
   rsp_type    rsp_head;

   assign req_full = q_full;

   bsrm_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_code_byte (req_code_byte),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_op          (front_op)
   );

   bsrm_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .push_op (front_op),
      .full    (q_full),
      .pop     (q_pop),
      .empty   (q_empty),
      .head_op (head_op)
   );

   bsrm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_op      (head_op),
      .q_pop     (q_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_head  (rsp_head)
   );

   assign rsp_status    = rsp_head.status;
   assign rsp_wrote_reg = rsp_head.wrote_reg;
   assign rsp_reg_index = rsp_head.reg_index;
   assign rsp_reg_value = rsp_head.reg_value;
   assign rsp_flags     = rsp_head.flags;
   assign rsp_position  = rsp_head.position;

endmodule

FILE: design/bsrm_checker.sv
// ----------------------------------------------------------------------------
// bsrm_checker
// Port-level checks of the byte stream register machine, bound to the top.
// ----------------------------------------------------------------------------
module bsrm_checker
   import bsrm_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_full,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic [2:0]  rsp_status,
   input logic        rsp_wrote_reg,
   input logic [2:0]  rsp_reg_index,
   input logic [15:0] rsp_reg_value,
   input logic [1:0]  rsp_flags,
   input logic [10:0] rsp_position
);

   a_reset_empties: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("queues not empty after reset");

   a_no_write_zero: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_wrote_reg |-> rsp_reg_index == 3'd0 && rsp_reg_value == 16'd0)
      else $error("register fields set without a write");

   a_write_done: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_wrote_reg |->
         rsp_status == ST_DONE && rsp_reg_index < 3'(NUM_REGS))
      else $error("register write with wrong status or index");

   a_halt_position: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_status == ST_HALT |-> rsp_position == 11'd0)
      else $error("halted result with nonzero position");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_status)
         && $stable(rsp_reg_value) && $stable(rsp_flags) && $stable(rsp_position))
      else $error("stalled result changed");

endmodule

bind byte_stream_register_machine_top bsrm_checker u_bsrm_checker (.*);

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Runs one program through the byte stream register machine. The program
// starts with a short directed sequence of every operation but return, with
// the add and subtract wrap-around. It goes on with random well-formed
// instructions that fill most of the program space. It ends with one
// randomly chosen halt: return, bad opcode, bad destination, bad source, or
// running out of space. Random bytes are then sent to the halted machine.
// A behavioral model of the machine predicts each result, and every popped
// transaction is checked field by field against the oldest prediction.
// Both sides idle at random. The receiver also holds off once for a long
// stretch so that the block fills up and stalls its input.
// ----------------------------------------------------------------------------
module tb;
   import bsrm_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT = 1_000_000;
   localparam int unsigned LONG_HOLD   = 300;
   localparam int unsigned MAX_PRINTS  = 40;

   typedef enum {
      END_RET,
      END_BADOP,
      END_BADDEST,
      END_BADSRC,
      END_SPACE
   } ending_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_push;
   logic        req_full;
   logic [7:0]  req_code_byte;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [2:0]  rsp_status;
   logic        rsp_wrote_reg;
   logic [2:0]  rsp_reg_index;
   logic [15:0] rsp_reg_value;
   logic [1:0]  rsp_flags;
   logic [10:0] rsp_position;

   rsp_type     predicted_results[$];
   int unsigned mismatch_count = 0;
   int unsigned results_seen   = 0;
   int unsigned cycle_count    = 0;
   int unsigned hold_left      = 0;
   int unsigned stall_left     = 0;
   bit          hold_request   = 1'b0;
   bit          fast_mode      = 1'b0;

   logic [15:0] mach_regs [0:7] = '{default: 16'h0000};
   logic [1:0]  mach_flags  = 2'b00;
   phase_type   mach_phase  = PH_OPCODE;
   opk_type     mach_op     = OPK_LDI;
   logic [2:0]  mach_dest   = 3'd0;
   logic [7:0]  mach_low    = 8'h00;
   int unsigned mach_pos    = 0;
   bit          mach_halted = 1'b0;

   logic [7:0]  opcodes [0:4] = '{OP_LDI, OP_ADDI, OP_SUBI, OP_MOVR, OP_CMP};

   byte_stream_register_machine_top uut (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_code_byte (req_code_byte),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_status    (rsp_status),
      .rsp_wrote_reg (rsp_wrote_reg),
      .rsp_reg_index (rsp_reg_index),
      .rsp_reg_value (rsp_reg_value),
      .rsp_flags     (rsp_flags),
      .rsp_position  (rsp_position)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Advances the machine by one program byte and returns the result it gives.
   function automatic rsp_type execute_byte(input logic [7:0] b);
      rsp_type     r;
      int unsigned at;
      logic [15:0] src_val;
      logic [15:0] imm;
      r = '0;
      r.status = ST_PEND;
      if (mach_halted) begin
         r.status = ST_HALT;
         r.flags  = mach_flags;
         return r;
      end
      at = mach_pos;
      r.position = at[10:0];
      if (mach_pos < PROGRAM_BYTES) mach_pos++;
      if (at >= PROGRAM_BYTES) begin
         r.status = ST_SPACE;
         mach_halted = 1'b1;
      end else begin
         case (mach_phase)
            PH_OPCODE: begin
               mach_phase = PH_DEST;
               case (b)
                  OP_LDI:  mach_op = OPK_LDI;
                  OP_ADDI: mach_op = OPK_ADDI;
                  OP_SUBI: mach_op = OPK_SUBI;
                  OP_MOVR: mach_op = OPK_MOVR;
                  OP_CMP:  mach_op = OPK_CMP;
                  OP_RET: begin
                     r.status = ST_RET;
                     mach_halted = 1'b1;
                     mach_phase = PH_OPCODE;
                  end
                  default: begin
                     r.status = ST_BADOP;
                     mach_halted = 1'b1;
                     mach_phase = PH_OPCODE;
                  end
               endcase
            end
            PH_DEST: begin
               if (b >= NUM_REGS) begin
                  r.status = ST_BADREG;
                  mach_halted = 1'b1;
                  mach_phase = PH_OPCODE;
               end else begin
                  mach_dest = b[2:0];
                  mach_phase = PH_OPND;
               end
            end
            PH_OPND: begin
               if (mach_op == OPK_MOVR || mach_op == OPK_CMP) begin
                  mach_phase = PH_OPCODE;
                  if (b >= NUM_REGS) begin
                     r.status = ST_BADREG;
                     mach_halted = 1'b1;
                  end else begin
                     src_val = mach_regs[b[2:0]];
                     r.status = ST_DONE;
                     if (mach_op == OPK_MOVR) begin
                        mach_regs[mach_dest] = src_val;
                        r.wrote_reg = 1'b1;
                        r.reg_index = mach_dest;
                        r.reg_value = src_val;
                     end else begin
                        mach_flags = mach_flags |
                           ((mach_regs[mach_dest] == src_val) ? FLAG_EQ : FLAG_NE);
                     end
                  end
               end else begin
                  mach_low = b;
                  mach_phase = PH_HIGH;
               end
            end
            default: begin
               imm = {b, mach_low};
               case (mach_op)
                  OPK_ADDI: mach_regs[mach_dest] = mach_regs[mach_dest] + imm;
                  OPK_SUBI: mach_regs[mach_dest] = mach_regs[mach_dest] - imm;
                  default:  mach_regs[mach_dest] = imm;
               endcase
               mach_phase = PH_OPCODE;
               r.status = ST_DONE;
               r.wrote_reg = 1'b1;
               r.reg_index = mach_dest;
               r.reg_value = mach_regs[mach_dest];
            end
         endcase
      end
      r.flags = mach_flags;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTS)
         $display("MISMATCH transaction %0d %s: got %0h, expected %0h",
                  results_seen, what, got, want);
   endtask

   task automatic check_result();
      rsp_type want;
      results_seen++;
      if (predicted_results.size() == 0) begin
         report_mismatch("unexpected result", rsp_status, 0);
         return;
      end
      want = predicted_results.pop_front();
      if (rsp_status !== want.status) report_mismatch("status", rsp_status, want.status);
      if (rsp_wrote_reg !== want.wrote_reg)
         report_mismatch("wrote_reg", rsp_wrote_reg, want.wrote_reg);
      if (rsp_reg_index !== want.reg_index)
         report_mismatch("reg_index", rsp_reg_index, want.reg_index);
      if (rsp_reg_value !== want.reg_value)
         report_mismatch("reg_value", rsp_reg_value, want.reg_value);
      if (rsp_flags !== want.flags) report_mismatch("flags", rsp_flags, want.flags);
      if (rsp_position !== want.position)
         report_mismatch("position", rsp_position, want.position);
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_pop && !rsp_empty) check_result();
         if (hold_request) begin
            hold_left = LONG_HOLD;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else if (fast_mode) begin
            rsp_pop <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
            stall_left = pick_gap();
         end
      end
   end

   task automatic send_byte(input logic [7:0] b);
      int unsigned gap;
      gap = fast_mode ? 0 : pick_gap();
      if (gap != 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_code_byte <= b;
      do @(posedge clock); while (req_full);
      predicted_results.push_back(execute_byte(b));
   endtask

   task automatic send_imm(input logic [7:0] op, input logic [7:0] dest,
                           input logic [15:0] imm);
      send_byte(op);
      send_byte(dest);
      send_byte(imm[7:0]);
      send_byte(imm[15:8]);
   endtask

   task automatic send_reg(input logic [7:0] op, input logic [7:0] dest,
                           input logic [7:0] src);
      send_byte(op);
      send_byte(dest);
      send_byte(src);
   endtask

   task automatic send_random_instruction();
      logic [7:0]  op;
      logic [7:0]  dest;
      logic [15:0] imm;
      op = opcodes[3'($urandom_range(0, 4))];
      dest = 8'($urandom_range(0, NUM_REGS - 1));
      case ($urandom_range(0, 7))
         0:       imm = 16'h0000;
         1:       imm = 16'hFFFF;
         2:       imm = 16'h8000;
         3:       imm = 16'h0001;
         default: imm = 16'($urandom_range(0, 16'hFFFF));
      endcase
      if (op == OP_MOVR || op == OP_CMP)
         send_reg(op, dest, ($urandom_range(0, 3) == 0)
                               ? dest : 8'($urandom_range(0, NUM_REGS - 1)));
      else
         send_imm(op, dest, imm);
   endtask

   task automatic test_directed_ops();
      send_imm(OP_LDI, 8'd0, 16'hFFFF);
      send_imm(OP_ADDI, 8'd0, 16'h0001);
      send_imm(OP_SUBI, 8'd1, 16'h0001);
      send_reg(OP_MOVR, 8'd5, 8'd1);
      send_reg(OP_CMP, 8'd5, 8'd1);
      send_reg(OP_CMP, 8'd0, 8'd5);
      send_imm(OP_LDI, 8'd5, 16'h8001);
   endtask

   task automatic test_random_program(input int unsigned stop_at);
      int unsigned count;
      count = 0;
      while (mach_pos + 4 <= stop_at && !mach_halted) begin
         if (count == 30) hold_request = 1'b1;
         fast_mode = (count >= 100 && count < 160);
         send_random_instruction();
         count++;
      end
      fast_mode = 1'b0;
   endtask

   task automatic test_program_end(input ending_type kind);
      logic [7:0] b;
      case (kind)
         END_RET: send_byte(OP_RET);
         END_BADOP: begin
            do b = 8'($urandom_range(0, 255));
            while (b inside {OP_LDI, OP_ADDI, OP_SUBI, OP_MOVR, OP_CMP, OP_RET});
            send_byte(b);
         end
         END_BADDEST: begin
            send_byte(opcodes[3'($urandom_range(0, 4))]);
            send_byte(8'($urandom_range(NUM_REGS, 255)));
         end
         END_BADSRC: begin
            send_reg($urandom_range(0, 1) ? OP_MOVR : OP_CMP,
                     8'($urandom_range(0, NUM_REGS - 1)),
                     8'($urandom_range(NUM_REGS, 255)));
         end
         default: ;
      endcase
   endtask

   task automatic test_halted_bytes();
      repeat (80) send_byte(8'($urandom_range(0, 255)));
   endtask

   initial begin
      ending_type ending;
      reset = 1'b1;
      req_push = 1'b0;
      req_code_byte = 8'h00;
      ending = ending_type'($urandom_range(0, 4));
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_directed_ops();
      test_random_program((ending == END_SPACE) ? PROGRAM_BYTES + 4
                                                : $urandom_range(960, 1016));
      test_program_end(ending);
      test_halted_bytes();
      req_push <= 1'b0;
      while (predicted_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

FILE: byte_stream_register_machine_top.f
design/bsrm_pkg.sv
design/bsrm_front.sv
design/bsrm_queue.sv
design/bsrm_back.sv
design/byte_stream_register_machine_top.sv
design/bsrm_checker.sv
test/tb.sv
